FILE: rtl/core/abrb_pkg.sv
// Shared constants, types and helper functions for the audio block ring buffer.
package abrb_pkg;

   // Ring geometry.
   localparam int BLOCK_COUNT      = 16;
   localparam int FRAMES_PER_BLOCK = 64;
   localparam int STORE_DEPTH      = BLOCK_COUNT * FRAMES_PER_BLOCK;

   // Derived widths.
   localparam int BLOCK_W  = $clog2(BLOCK_COUNT);
   localparam int BLKX_W   = BLOCK_W + 1;
   localparam int OFFS_W   = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int FRAME_W  = 32;
   localparam int HALF_W   = FRAME_W / 2;
   localparam int FREE_W   = 10;

   // Command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [OFFS_W-1:0]  LAST_OFF   = OFFS_W'(FRAMES_PER_BLOCK - 1);
   localparam logic [BLOCK_W-1:0] LAST_BLOCK = BLOCK_W'(BLOCK_COUNT - 1);
   localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(STORE_DEPTH - 1);

   // Command kinds, taken from the func field of an input beat.
   typedef enum logic {
      CMD_WRITE      = 1'b0,
      CMD_BLOCK_DONE = 1'b1
   } cmd_kind_type;

   // One classified command as it sits in the queue.
   typedef struct packed {
      cmd_kind_type       kind;
      logic [FRAME_W-1:0] frame;
   } cmd_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_CLEAR,
      BK_READ,
      BK_SEND
   } back_state_type;

   // Swap the two 16-bit halves of a stereo frame.
   function automatic logic [FRAME_W-1:0] swap_halves(input logic [FRAME_W-1:0] s);
      return {s[HALF_W-1:0], s[FRAME_W-1:HALF_W]};
   endfunction

   // Step a block number around the ring.
   function automatic logic [BLOCK_W-1:0] step_block(input logic [BLOCK_W-1:0] b);
      logic [BLOCK_W-1:0] r;
      if (b == LAST_BLOCK) begin
         r = '0;
      end else begin
         r = BLOCK_W'(b + 1'b1);
      end
      return r;
   endfunction

   // Flat store address of a frame within a block.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [BLOCK_W-1:0] blk,
                                                   input logic [OFFS_W-1:0]  off);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(blk) * ADDR_W'(FRAMES_PER_BLOCK));
      return ADDR_W'(base + ADDR_W'(off));
   endfunction

   // Free space in frames: blocks from write up to busy, times the block size.
   function automatic logic [FREE_W-1:0] free_count(input logic [BLOCK_W-1:0] busy,
                                                   input logic [BLOCK_W-1:0] wr);
      logic [BLKX_W-1:0] blocks;
      logic [31:0]       prod;
      if (busy >= wr) begin
         blocks = BLKX_W'({1'b0, busy} - {1'b0, wr});
      end else begin
         blocks = BLKX_W'({1'b0, busy} + BLKX_W'(BLOCK_COUNT) - {1'b0, wr});
      end
      prod = 32'(blocks) * 32'(FRAMES_PER_BLOCK);
      return prod[FREE_W-1:0];
   endfunction

endpackage

FILE: rtl/core/abrb_channels.sv
// Handshake channel interfaces for the request, response and control ports.
interface abrb_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [abrb_pkg::FRAME_W-1:0] sample;

   modport source (output valid, func, sample, input ready);
   modport sink   (input valid, func, sample, output ready);
endinterface

interface abrb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         is_playback;
   logic                         accepted;
   logic [abrb_pkg::FRAME_W-1:0] out_frame;
   logic                         last;
   logic [abrb_pkg::FREE_W-1:0]  free_frames;

   modport source (output valid, is_playback, accepted, out_frame, last, free_frames,
                   input ready);
   modport sink   (input valid, is_playback, accepted, out_frame, last, free_frames,
                   output ready);
endinterface

interface abrb_csr_if;
   logic valid;
   logic ready;
   logic nonblocking;

   modport source (output valid, nonblocking, input ready);
   modport sink   (input valid, nonblocking, output ready);
endinterface

FILE: rtl/core/abrb_front.sv
// Front end: accepts request beats, classifies them and queues the commands.
module abrb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_en,
   abrb_req_if.sink          req_if,
   output abrb_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_ready
);
   import abrb_pkg::*;

   cmd_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   cmd_type            req_cmd;
   logic               push;
   logic               pop;

   // Room in the queue, and only once the store has been cleared after reset.
   assign req_if.ready = accept_en && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign pop          = cmd_valid && cmd_ready;

   // Classify the beat; frames are stored with their halves swapped.
   always_comb begin
      req_cmd.kind = cmd_kind_type'(req_if.func);
      if (req_cmd.kind == CMD_BLOCK_DONE) begin
         req_cmd.frame = '0;
      end else begin
         req_cmd.frame = swap_halves(req_if.sample);
      end
   end

   // Queue pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = QCNT_W'(count_ff + 1'b1);
         2'b01:   count_in = QCNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_cmd;
      end
   end

   assign cmd       = q_ff[rd_ptr_ff];
   assign cmd_valid = (count_ff != '0);

endmodule

FILE: rtl/core/abrb_back.sv
// Back end: ring state, frame store, block clearing and playback streaming.
module abrb_back (
   input  logic              clock,
   input  logic              reset,
   input  abrb_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   output logic              init_done,
   abrb_rsp_if.source        rsp_if,
   abrb_csr_if.sink          csr_if
);
   import abrb_pkg::*;

   back_state_type      state_ff, state_in;
   logic [BLOCK_W-1:0]  busy_ff, busy_in;
   logic [BLOCK_W-1:0]  next_ff, next_in;
   logic [BLOCK_W-1:0]  wblk_ff, wblk_in;
   logic [OFFS_W-1:0]   woff_ff, woff_in;
   logic [OFFS_W-1:0]   off_ff, off_in;
   logic [ADDR_W-1:0]   init_addr_ff, init_addr_in;
   logic                nonblocking_ff, nonblocking_in;

   // Output register.
   logic                out_valid_ff, out_valid_in;
   logic                out_play_ff, out_play_in;
   logic                out_acc_ff, out_acc_in;
   logic [FRAME_W-1:0]  out_frame_ff, out_frame_in;
   logic                out_last_ff, out_last_in;
   logic [FREE_W-1:0]   out_free_ff, out_free_in;
   logic                out_room;

   // Frame store.
   logic [FRAME_W-1:0]  mem [STORE_DEPTH];
   logic [FRAME_W-1:0]  rd_data_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [FRAME_W-1:0]  mem_wdata;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_raddr;
   logic                ring_full;

   assign out_room  = !out_valid_ff || rsp_if.ready;
   assign ring_full = (wblk_ff == next_ff) || (wblk_ff == busy_ff);
   assign init_done = (state_ff != BK_INIT);

   // Control register; the user makes writes only while the block is idle (unchecked here).
   assign csr_if.ready   = 1'b1;
   assign nonblocking_in = (csr_if.valid && csr_if.ready) ? csr_if.nonblocking
                                                          : nonblocking_ff;

   // Sequencer: next state, store accesses and result loading.
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      next_in      = next_ff;
      wblk_in      = wblk_ff;
      woff_in      = woff_ff;
      off_in       = off_ff;
      init_addr_in = init_addr_ff;
      cmd_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_play_in  = out_play_ff;
      out_acc_in   = out_acc_ff;
      out_frame_in = out_frame_ff;
      out_last_in  = out_last_ff;
      out_free_in  = out_free_ff;

      unique case (state_ff)
         // Zero the whole store once after reset.
         BK_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_addr_ff;
            if (init_addr_ff == LAST_ADDR) begin
               state_in = BK_IDLE;
            end else begin
               init_addr_in = ADDR_W'(init_addr_ff + 1'b1);
            end
         end

         // Take one command when the output register can hold its result.
         BK_IDLE: begin
            if (cmd_valid && out_room) begin
               cmd_ready = 1'b1;
               if (cmd.kind == CMD_BLOCK_DONE) begin
                  off_in   = '0;
                  state_in = BK_CLEAR;
               end else begin
                  out_valid_in = 1'b1;
                  out_play_in  = 1'b0;
                  out_frame_in = '0;
                  out_last_in  = 1'b1;
                  if (ring_full && !nonblocking_ff) begin
                     out_acc_in  = 1'b0;
                     out_free_in = free_count(busy_ff, wblk_ff);
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = store_addr(wblk_ff, woff_ff);
                     mem_wdata = cmd.frame;
                     if (woff_ff == LAST_OFF) begin
                        woff_in = '0;
                        wblk_in = step_block(wblk_ff);
                     end else begin
                        woff_in = OFFS_W'(woff_ff + 1'b1);
                     end
                     out_acc_in  = 1'b1;
                     out_free_in = free_count(busy_ff, wblk_in);
                  end
               end
            end
         end

         // Zero the block that just finished, then rotate busy and next.
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = store_addr(busy_ff, off_ff);
            if (off_ff == LAST_OFF) begin
               off_in   = '0;
               busy_in  = next_ff;
               next_in  = step_block(next_ff);
               state_in = BK_READ;
            end else begin
               off_in = OFFS_W'(off_ff + 1'b1);
            end
         end

         // Fetch one frame of the new next block.
         BK_READ: begin
            mem_re    = 1'b1;
            mem_raddr = store_addr(next_ff, off_ff);
            state_in  = BK_SEND;
         end

         // Hand the fetched frame to the output register.
         BK_SEND: begin
            if (out_room) begin
               out_valid_in = 1'b1;
               out_play_in  = 1'b1;
               out_acc_in   = 1'b0;
               out_frame_in = rd_data_ff;
               out_last_in  = (off_ff == LAST_OFF);
               out_free_in  = free_count(busy_ff, wblk_ff);
               if (off_ff == LAST_OFF) begin
                  off_in   = '0;
                  state_in = BK_IDLE;
               end else begin
                  off_in   = OFFS_W'(off_ff + 1'b1);
                  state_in = BK_READ;
               end
            end
         end

         default: begin
            state_in = BK_INIT;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_INIT;
         busy_ff        <= '0;
         next_ff        <= '0;
         wblk_ff        <= LAST_BLOCK;
         woff_ff        <= '0;
         off_ff         <= '0;
         init_addr_ff   <= '0;
         nonblocking_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         busy_ff        <= busy_in;
         next_ff        <= next_in;
         wblk_ff        <= wblk_in;
         woff_ff        <= woff_in;
         off_ff         <= off_in;
         init_addr_ff   <= init_addr_in;
         nonblocking_ff <= nonblocking_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_play_ff  <= out_play_in;
      out_acc_ff   <= out_acc_in;
      out_frame_ff <= out_frame_in;
      out_last_ff  <= out_last_in;
      out_free_ff  <= out_free_in;
   end

   // Frame store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.is_playback = out_play_ff;
   assign rsp_if.accepted    = out_acc_ff;
   assign rsp_if.out_frame   = out_frame_ff;
   assign rsp_if.last        = out_last_ff;
   assign rsp_if.free_frames = out_free_ff;

   // No command is taken while the store is still being cleared.
   a_no_cmd_during_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_INIT) |-> (!cmd_ready && !init_done))
      else $error("command taken during store clearing");

   // The write offset never runs past the end of a block.
   a_woff_range: assert property (@(posedge clock) disable iff (reset)
      woff_ff <= LAST_OFF)
      else $error("write offset out of range");

   // While streaming, the next block is never the one being played.
   a_stream_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |-> (next_ff != busy_ff))
      else $error("streaming the busy block");

   // The final streamed frame carries last and returns the sequencer to idle.
   a_stream_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SEND && out_room && off_ff == LAST_OFF)
      |=> (state_ff == BK_IDLE && out_valid_ff && rsp_if.last && rsp_if.is_playback))
      else $error("block stream did not end cleanly");

endmodule

FILE: rtl/core/audio_block_ring_buffer.sv
// Top level of the audio block ring buffer: front end, command queue and back end.
//
//   Channel   Dir   Beat contents
//   req_if    in    func (0 write frame, 1 block done), sample
//   rsp_if    out   is_playback, accepted, out_frame, last, free_frames
//   csr_if    in    nonblocking mode bit
//
// A frame write is handled in the idle state, so writes sustain one beat per cycle
// while rsp_if is not stalled. A block-done event zeroes the finished block frame by
// frame (BK_CLEAR), then streams the new next block through a store read (BK_READ) and
// a send (BK_SEND) per frame. After reset the store is cleared; req_if.ready stays low.
// A stalled response holds the back end; the two-entry queue accepts until it is full.
module audio_block_ring_buffer (
   input  logic       clock,
   input  logic       reset,
   abrb_req_if.sink   req_if,
   abrb_rsp_if.source rsp_if,
   abrb_csr_if.sink   csr_if
);
   import abrb_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;
   logic    init_done;

   abrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (init_done),
      .req_if    (req_if),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   abrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .init_done (init_done),
      .rsp_if    (rsp_if),
      .csr_if    (csr_if)
   );

endmodule

FILE: tb/tb_audio_block_ring_buffer.sv
// Self-checking testbench for the audio block ring buffer, with a tracking ring model.
`timescale 1ns / 1ps

module tb_audio_block_ring_buffer;
   import abrb_pkg::*;

   // One response beat as the ring should produce it.
   typedef struct packed {
      logic               is_playback;
      logic               accepted;
      logic [FRAME_W-1:0] out_frame;
      logic               last;
      logic [FREE_W-1:0]  free_frames;
   } ring_beat_type;

   logic clock = 1'b0;
   logic reset;

   abrb_req_if req_if();
   abrb_rsp_if rsp_if();
   abrb_csr_if csr_if();

   audio_block_ring_buffer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Commands waiting for the request driver, and beats the ring still owes us.
   cmd_type       ring_cmds[$];
   ring_beat_type owed_beats[$];

   // Tracking copy of the ring state.
   logic [FRAME_W-1:0] frame_mem [STORE_DEPTH];
   logic [BLOCK_W-1:0] busy_blk;
   logic [BLOCK_W-1:0] next_blk;
   logic [BLOCK_W-1:0] write_blk;
   logic [OFFS_W-1:0]  write_off;
   logic               nb_mode;

   int src_idle_pct;
   int snk_idle_pct;
   int err_count;
   int stored_cnt;
   int overrun_cnt;
   int refused_cnt;
   int done_cnt;
   int beats_seen;
   int mode_writes;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [BLOCK_W-1:0] ring_advance(input logic [BLOCK_W-1:0] b);
      return (int'(b) == BLOCK_COUNT - 1) ? '0 : BLOCK_W'(b + 1'b1);
   endfunction

   // Free space counts the whole blocks from the write block round to the busy block.
   function automatic logic [FREE_W-1:0] ring_free_frames();
      int unsigned blocks;
      blocks = (int'(busy_blk) + BLOCK_COUNT - int'(write_blk)) % BLOCK_COUNT;
      return FREE_W'(blocks * FRAMES_PER_BLOCK);
   endfunction

   // Apply one accepted command to the ring copy and queue the beats it owes.
   task automatic ring_apply(input cmd_kind_type kind, input logic [FRAME_W-1:0] sample);
      ring_beat_type beat;
      logic          full;
      logic          swapped_ok;
      beat = '0;
      if (kind == CMD_WRITE) begin
         full = (write_blk == next_blk) || (write_blk == busy_blk);
         swapped_ok = !full || nb_mode;
         if (swapped_ok) begin
            frame_mem[int'(write_blk) * FRAMES_PER_BLOCK + int'(write_off)] =
               {sample[HALF_W-1:0], sample[FRAME_W-1:HALF_W]};
            if (int'(write_off) == FRAMES_PER_BLOCK - 1) begin
               write_off = '0;
               write_blk = ring_advance(write_blk);
            end else begin
               write_off = OFFS_W'(write_off + 1'b1);
            end
            beat.accepted = 1'b1;
            stored_cnt++;
            if (full) begin
               overrun_cnt++;
            end
         end else begin
            refused_cnt++;
         end
         beat.last        = 1'b1;
         beat.free_frames = ring_free_frames();
         owed_beats.push_back(beat);
      end else begin
         // The finished block is zeroed before the new next block is streamed.
         for (int i = 0; i < FRAMES_PER_BLOCK; i++) begin
            frame_mem[int'(busy_blk) * FRAMES_PER_BLOCK + i] = '0;
         end
         busy_blk = next_blk;
         next_blk = ring_advance(next_blk);
         beat.is_playback = 1'b1;
         beat.free_frames = ring_free_frames();
         for (int i = 0; i < FRAMES_PER_BLOCK; i++) begin
            beat.out_frame = frame_mem[int'(next_blk) * FRAMES_PER_BLOCK + i];
            beat.last      = (i == FRAMES_PER_BLOCK - 1);
            owed_beats.push_back(beat);
         end
         done_cnt++;
      end
   endtask

   // Request driver: presents queued commands and feeds each accepted beat to the ring copy.
   always @(posedge clock) begin : req_driver
      cmd_type cmd;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            ring_apply(cmd_kind_type'(req_if.func), req_if.sample);
         end
         if (!req_if.valid || req_if.ready) begin
            if (ring_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               cmd = ring_cmds.pop_front();
               req_if.valid  <= 1'b1;
               req_if.func   <= cmd.kind;
               req_if.sample <= cmd.frame;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [FRAME_W-1:0] want,
                                       input logic [FRAME_W-1:0] got);
      if (want !== got) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   // Response monitor: checks every accepted beat against the oldest owed beat.
   always @(posedge clock) begin : rsp_monitor
      ring_beat_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (owed_beats.size() == 0) begin
               err_count++;
               $display("%0t: unexpected beat, expected none, got frame %h last %b",
                        $time, rsp_if.out_frame, rsp_if.last);
            end else begin
               want = owed_beats.pop_front();
               check_field("is_playback", FRAME_W'(want.is_playback),
                           FRAME_W'(rsp_if.is_playback));
               check_field("accepted", FRAME_W'(want.accepted), FRAME_W'(rsp_if.accepted));
               check_field("out_frame", want.out_frame, rsp_if.out_frame);
               check_field("last", FRAME_W'(want.last), FRAME_W'(rsp_if.last));
               check_field("free_frames", FRAME_W'(want.free_frames),
                           FRAME_W'(rsp_if.free_frames));
               beats_seen++;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   task automatic push_cmd(input cmd_kind_type kind, input logic [FRAME_W-1:0] sample);
      cmd_type cmd;
      cmd.kind  = kind;
      cmd.frame = sample;
      ring_cmds.push_back(cmd);
   endtask

   // Block until nothing is queued, on the wire or owed by the ring.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (ring_cmds.size() != 0 || req_if.valid || owed_beats.size() != 0);
   endtask

   // Mode writes only happen with the ring idle.
   task automatic write_mode(input logic nb);
      wait_drained();
      @(posedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.nonblocking <= nb;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      nb_mode = nb;
      mode_writes++;
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [FRAME_W-1:0] pick_sample();
      unique case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 32'h0000_FFFF;
         3:       return 32'hFFFF_0000;
         default: return $urandom();
      endcase
   endfunction

   // Producer bursts of frames, each followed by one or two block-done events.
   task automatic queue_traffic(input int count);
      int left;
      int burst;
      @(negedge clock);
      left = count;
      while (left > 0) begin
         burst = $urandom_range(40);
         if (burst > left - 1) begin
            burst = left - 1;
         end
         repeat (burst) push_cmd(CMD_WRITE, pick_sample());
         push_cmd(CMD_BLOCK_DONE, '0);
         left -= burst + 1;
         if (left > 0 && $urandom_range(3) == 0) begin
            push_cmd(CMD_BLOCK_DONE, '0);
            left--;
         end
      end
   endtask

   // One phase: idle mix and mode, then traffic with a full drain in the middle.
   task automatic run_phase(input logic nb, input int src_pct, input int snk_pct,
                            input int count);
      wait_drained();
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      write_mode(nb);
      queue_traffic(count / 2);
      wait_drained();
      queue_traffic(count - count / 2);
   endtask

   initial begin : stimulus
      req_if.valid       = 1'b0;
      req_if.func        = CMD_WRITE;
      req_if.sample      = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.nonblocking = 1'b0;
      reset              = 1'b1;
      src_idle_pct       = 35;
      snk_idle_pct       = 77;
      err_count          = 0;
      stored_cnt         = 0;
      overrun_cnt        = 0;
      refused_cnt        = 0;
      done_cnt           = 0;
      beats_seen         = 0;
      mode_writes        = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         frame_mem[i] = '0;
      end
      busy_blk  = '0;
      next_blk  = '0;
      write_blk = LAST_BLOCK;
      write_off = '0;
      nb_mode   = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // Directed: extreme frames into the last block, then enough block-done events
      // to walk next up to the write block, which makes the ring refuse writes.
      @(negedge clock);
      push_cmd(CMD_WRITE, 32'h0000_0000);
      push_cmd(CMD_WRITE, 32'hFFFF_FFFF);
      push_cmd(CMD_WRITE, 32'h0000_FFFF);
      push_cmd(CMD_WRITE, 32'hFFFF_0000);
      push_cmd(CMD_WRITE, 32'h1234_5678);
      push_cmd(CMD_WRITE, 32'h8000_0001);
      repeat (BLOCK_COUNT - 1) push_cmd(CMD_BLOCK_DONE, '0);
      push_cmd(CMD_WRITE, 32'hA5A5_5A5A);
      push_cmd(CMD_WRITE, 32'h7FFF_8000);

      run_phase(1'b0, 35, 77, 75);
      run_phase(1'b1, 35, 77, 75);
      run_phase(1'b0, 77, 35, 75);
      run_phase(1'b1, 0, 0, 75);

      wait_drained();
      repeat (400) @(negedge clock);

      $display("run: %0d frames stored (%0d over a full ring), %0d refused, %0d block-done",
               stored_cnt, overrun_cnt, refused_cnt, done_cnt);
      $display("run: %0d response beats checked over %0d mode writes, %0d errors",
               beats_seen, mode_writes, err_count);
      if (err_count == 0 && owed_beats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/abrb_pkg.sv
rtl/core/abrb_channels.sv
rtl/core/abrb_front.sv
rtl/core/abrb_back.sv
rtl/core/audio_block_ring_buffer.sv
tb/tb_audio_block_ring_buffer.sv
